// ----- rtl/core/tag_stack_with_topmost_search_assert.svh -----
// ---------------------------------------------------------------------------
// tag stack assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef TAG_STACK_WITH_TOPMOST_SEARCH_ASSERT_SVH
`define TAG_STACK_WITH_TOPMOST_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TSTK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tag stack check failed");

// antecedent implies consequent in the next cycle
`define TSTK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tag stack check failed");

`else

`define TSTK_ASSERT_SAME(label, clk, rst, ante, cons)
`define TSTK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/tstk_pkg.sv -----
// ---------------------------------------------------------------------------
// tstk_pkg
// shared field widths, operation and status codes, and the command and
// status bundles between the tag stack controller and datapath
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tstk_pkg;

   // request and result field widths
   localparam int FUNC_W   = 3;
   localparam int TAG_W    = 8;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 3;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_IDX = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_TOP = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_FIND     = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // register word index
   localparam logic CSR_UNKNOWN_TAG = 1'b0;

   // memory read source
   typedef enum logic [1:0] {
      RD_NONE  = 2'd0,
      RD_TOP   = 2'd1,
      RD_INDEX = 2'd2,
      RD_NEXT  = 2'd3
   } rd_type;

   // result register update
   typedef enum logic [2:0] {
      RES_HOLD      = 3'd0,
      RES_NONE      = 3'd1,
      RES_DATA      = 3'd2,
      RES_FULL      = 3'd3,
      RES_EMPTY     = 3'd4,
      RES_RANGE     = 3'd5,
      RES_NOT_FOUND = 3'd6,
      RES_FOUND     = 3'd7
   } res_type;

   typedef struct packed {
      logic    latch_req;
      logic    do_clear;
      logic    do_push;
      logic    do_pop;
      rd_type  rd_sel;
      res_type res;
      logic    load_out;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              full;
      logic              idx_ok;
      logic              match;
      logic              ptr_zero;
      logic              out_free;
   } sts_type;

endpackage

// ----- rtl/core/tstk_ctrl.sv -----
// ---------------------------------------------------------------------------
// tstk_ctrl
// request sequencer: decodes the latched operation, walks the search from
// the top entry down and hands each result to the output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tstk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tstk_pkg::sts_type sts,
   output tstk_pkg::cmd_type cmd
);
   import tstk_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_READ = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = RD_NONE;
      cmd.res       = RES_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (sts.func)
               FUNC_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  cmd.res      = RES_NONE;
               end
               FUNC_PUSH: begin
                  if (sts.full) begin
                     cmd.res = RES_FULL;
                  end else begin
                     cmd.do_push = 1'b1;
                     cmd.res     = RES_NONE;
                  end
               end
               FUNC_POP: begin
                  if (sts.empty) begin
                     cmd.res = RES_EMPTY;
                  end else begin
                     cmd.do_pop = 1'b1;
                     cmd.rd_sel = RD_TOP;
                     state_in   = ST_READ;
                  end
               end
               FUNC_READ_IDX: begin
                  if (sts.idx_ok) begin
                     cmd.rd_sel = RD_INDEX;
                     state_in   = ST_READ;
                  end else begin
                     cmd.res = RES_RANGE;
                  end
               end
               FUNC_READ_TOP: begin
                  if (sts.empty) begin
                     cmd.res = RES_EMPTY;
                  end else begin
                     cmd.rd_sel = RD_TOP;
                     state_in   = ST_READ;
                  end
               end
               FUNC_FIND: begin
                  if (sts.empty) begin
                     cmd.res = RES_NOT_FOUND;
                  end else begin
                     cmd.rd_sel = RD_TOP;
                     state_in   = ST_SCAN;
                  end
               end
               default: begin
                  cmd.res = RES_NONE;
               end
            endcase
         end
         ST_READ: begin
            cmd.res  = RES_DATA;
            state_in = ST_OUT;
         end
         // one entry per cycle, top down
         ST_SCAN: begin
            if (sts.match) begin
               cmd.res  = RES_FOUND;
               state_in = ST_OUT;
            end else if (sts.ptr_zero) begin
               cmd.res  = RES_NOT_FOUND;
               state_in = ST_OUT;
            end else begin
               cmd.rd_sel = RD_NEXT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/tstk_dpath.sv -----
// ---------------------------------------------------------------------------
// tstk_dpath
// tag memory, fill count, scan pointer, result and output registers of the
// tag stack
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tstk_dpath #(
   parameter int STACK_DEPTH = 64,
   parameter int TAG_BITS    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tstk_pkg::cmd_type               cmd,
   output tstk_pkg::sts_type               sts,
   input  logic [tstk_pkg::FUNC_W-1:0]     req_func,
   input  logic [tstk_pkg::TAG_W-1:0]      req_tag,
   input  logic [tstk_pkg::INDEX_W-1:0]    req_index,
   input  logic [tstk_pkg::TAG_W-1:0]      unknown_code,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [tstk_pkg::TAG_W-1:0]      rsp_tag_out,
   output logic [tstk_pkg::INDEX_W-1:0]    rsp_position,
   output logic [tstk_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic [tstk_pkg::STATUS_W-1:0]   rsp_status
);
   import tstk_pkg::*;

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [TAG_BITS-1:0] tag_mem [STACK_DEPTH];

   logic [FUNC_W-1:0]   func_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       count_m1;
   logic [AW-1:0]       ptr_ff;
   logic [AW-1:0]       ptr_in;
   logic [AW-1:0]       ptr_m1;
   logic [AW-1:0]       rd_addr;
   logic                rd_en;
   logic [TAG_BITS-1:0] rd_data_ff;
   logic [CMPW-1:0]     index_cmp;
   logic [CMPW-1:0]     count_cmp;

   logic [TAG_W-1:0]    res_tag_ff;
   logic [TAG_W-1:0]    res_tag_in;
   logic [INDEX_W-1:0]  res_pos_ff;
   logic [INDEX_W-1:0]  res_pos_in;
   logic [STATUS_W-1:0] res_status_ff;
   logic [STATUS_W-1:0] res_status_in;

   logic                rsp_valid_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;
   logic [INDEX_W-1:0]  rsp_pos_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff  <= req_func;
         tag_ff   <= TAG_BITS'(req_tag);
         index_ff <= req_index;
      end
   end

   assign count_m1  = count_ff - CW'(1);
   assign ptr_m1    = ptr_ff - AW'(1);
   assign index_cmp = CMPW'(index_ff);
   assign count_cmp = CMPW'(count_ff);

   // fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.do_clear) begin
         count_in = '0;
      end else if (cmd.do_push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.do_pop) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // read address and scan pointer
   always_comb begin
      ptr_in  = ptr_ff;
      rd_addr = ptr_ff;
      rd_en   = 1'b1;
      case (cmd.rd_sel)
         RD_TOP: begin
            rd_addr = count_m1[AW-1:0];
            ptr_in  = count_m1[AW-1:0];
         end
         RD_INDEX: begin
            rd_addr = index_cmp[AW-1:0];
         end
         RD_NEXT: begin
            rd_addr = ptr_m1;
            ptr_in  = ptr_m1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   // tag memory write port
   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         tag_mem[count_ff[AW-1:0]] <= tag_ff;
      end
   end

   // tag memory read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tag_mem[rd_addr];
      end
   end

   // result selection
   always_comb begin
      res_tag_in    = res_tag_ff;
      res_pos_in    = res_pos_ff;
      res_status_in = res_status_ff;
      case (cmd.res)
         RES_NONE: begin
            res_tag_in    = unknown_code;
            res_pos_in    = '0;
            res_status_in = STATUS_OK;
         end
         RES_DATA: begin
            res_tag_in    = TAG_W'(rd_data_ff);
            res_pos_in    = '0;
            res_status_in = STATUS_OK;
         end
         RES_FULL: begin
            res_tag_in    = unknown_code;
            res_pos_in    = '0;
            res_status_in = STATUS_OVERFLOW;
         end
         RES_EMPTY: begin
            res_tag_in    = unknown_code;
            res_pos_in    = '0;
            res_status_in = STATUS_EMPTY;
         end
         RES_RANGE: begin
            res_tag_in    = unknown_code;
            res_pos_in    = '0;
            res_status_in = STATUS_RANGE;
         end
         RES_NOT_FOUND: begin
            res_tag_in    = unknown_code;
            res_pos_in    = '0;
            res_status_in = STATUS_NOT_FOUND;
         end
         RES_FOUND: begin
            res_tag_in    = unknown_code;
            res_pos_in    = INDEX_W'(ptr_ff);
            res_status_in = STATUS_OK;
         end
         default: begin
            res_tag_in    = res_tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_tag_ff    <= res_tag_in;
      res_pos_ff    <= res_pos_in;
      res_status_ff <= res_status_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tag_ff    <= res_tag_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tag_out     = rsp_tag_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // status to the controller
   assign sts.func     = func_ff;
   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CW'(STACK_DEPTH));
   assign sts.idx_ok   = (index_cmp < count_cmp);
   assign sts.match    = (rd_data_ff == tag_ff);
   assign sts.ptr_zero = (ptr_ff == '0);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// ----- rtl/core/tag_stack_with_topmost_search.sv -----
// ---------------------------------------------------------------------------
// tag_stack_with_topmost_search
// stack of open-element tag codes with clear, push, pop, indexed read, top
// read and a search for the topmost entry holding a tag
// ---------------------------------------------------------------------------
// sequence: accept, decode, then a memory read for pop and reads or a
//   top-down search for find, then the result and output registers
// one request in flight: the next request is accepted only after the result
//   is loaded, which waits while an earlier result waits on rsp_tready
// reset: synchronous; clears fill count, sequencer, output valid and unknown tag
//   register; tag memory contents are not cleared
`timescale 1ns / 1ps
`include "tag_stack_with_topmost_search_assert.svh"

module tag_stack_with_topmost_search #(
   parameter int STACK_DEPTH = 64,
   parameter int TAG_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tag [7:0], index [13:8], zero pad [15:14]
   input  logic [2:0]  req_tuser,   // func [2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tag_out [7:0], position [13:8],
                                    // entry_count [20:14], zero pad [23:21]
   output logic [2:0]  rsp_tuser,   // status [2:0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tstk_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [TAG_W-1:0]    unknown_code_ff;
   logic [TAG_W-1:0]    unknown_code_in;
   logic                csr_wr;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic [INDEX_W-1:0]  rsp_position;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [STATUS_W-1:0] rsp_status;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unknown_code_in = unknown_code_ff;
      if (csr_wr && (csr_paddr[2] == CSR_UNKNOWN_TAG)) begin
         unknown_code_in = csr_pwdata[TAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unknown_code_ff <= '0;
      end else begin
         unknown_code_ff <= unknown_code_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_UNKNOWN_TAG) ? {24'd0, unknown_code_ff} : 32'd0;

   // sequencer
   tstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and result path
   tstk_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_tuser),
      .req_tag         (req_tdata[7:0]),
      .req_index       (req_tdata[13:8]),
      .unknown_code    (unknown_code_ff),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   assign rsp_tdata = {3'd0, rsp_entry_count, rsp_position, rsp_tag_out};
   assign rsp_tuser = rsp_status;

   // one request in flight: no accept right after an accept
   `TSTK_ASSERT_NEXT(a_single_request, clock, reset, req_tvalid && req_tready, !req_tready)
   // result register only loaded when the output slot is free
   `TSTK_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_out, sts.out_free)
   // the search never steps below the bottom entry
   `TSTK_ASSERT_SAME(a_scan_floor, clock, reset, cmd.rd_sel == RD_NEXT, !sts.ptr_zero)
   // a clear empties the stack
   `TSTK_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.do_clear, sts.empty)

endmodule
